/* rtl/prsa_pkg.sv */
`default_nettype none

package prsa_pkg;

  localparam int PAGE_W    = 32;
  localparam int SLOT_W    = 12;
  localparam int SERIAL_W  = 32;
  localparam int OFFSET_W  = 16;
  localparam int SPP_W     = 13;
  localparam int TOTAL_W   = 17;
  localparam int COUNT_W   = 5;
  localparam int MAX_PAGES = 16;

  localparam logic [SPP_W-1:0] MAX_SLOTS = 13'd4096;
  localparam logic [SPP_W-1:0] SPP_RESET = 13'd64;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_SUCC    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 opcode;
    logic [PAGE_W-1:0]   page;
    logic [PAGE_W-1:0]   anchor_page;
    logic [SLOT_W-1:0]   slot;
    logic [SERIAL_W-1:0] serial;
    logic [OFFSET_W-1:0] offset;
  } in_t;

  typedef struct packed {
    status_t             status;
    logic [PAGE_W-1:0]   result_page;
    logic [SLOT_W-1:0]   result_slot;
    logic [SERIAL_W-1:0] result_serial;
    logic [COUNT_W-1:0]  page_count;
  } out_t;

endpackage

`default_nettype wire

/* rtl/page_ring_slot_address_unit.sv */
`default_nettype none

// Page ring slot address unit: keeps an ordered ring of up to MAX_PAGES page
// addresses in a one-port-read, one-port-write RAM and serves one operation per
// input beat (append, insert after anchor, advance a page/slot/serial position,
// successor page), returning one result beat carrying status and page count.
// Items are handled one at a time. Append writes the new page at the ring's end;
// successor runs a linear search over the ring, reading one RAM entry per
// cycle, then reads the following page; insert runs the search up to the
// anchor plus a one-entry-per-cycle shift of the later entries, so each
// entry is visited once; advance across pages runs the 17-step serial
// divider by slots_per_page alongside the search, then takes the hand-off
// of its result and the page lookup; advance within a page or out of range
// is answered from the range and page checks alone.
// A finished result sits in the output register while the next item is taken.
// slots_per_page may only be written while the unit is idle; 0 is stored as 1
// and values above 4096 as 4096.
module page_ring_slot_address_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [prsa_pkg::SPP_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire prsa_pkg::in_t              in_data,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      prsa_pkg::out_t             out_data
);

  localparam int AW   = (prsa_pkg::MAX_PAGES > 1) ? $clog2(prsa_pkg::MAX_PAGES) : 1;
  localparam int CW   = $clog2(prsa_pkg::MAX_PAGES + 1);
  localparam int PW   = CW + prsa_pkg::SPP_W;
  localparam int CMPW = (PW > prsa_pkg::OFFSET_W) ? PW : prsa_pkg::OFFSET_W;
  localparam logic [CW-1:0] MAX_LEN = CW'(prsa_pkg::MAX_PAGES);

  typedef enum logic [3:0] {
    S_IDLE, S_APPEND, S_ADV_CHK, S_SEARCH, S_AFTER,
    S_SHIFT, S_INS_WR, S_LK_RD, S_LK_DATA, S_DONE
  } state_t;

  state_t                       state;
  prsa_pkg::in_t                item;
  prsa_pkg::out_t               res;
  prsa_pkg::out_t               res_beat;
  logic                         out_load;
  logic [CW-1:0]                len;
  logic [prsa_pkg::SPP_W-1:0]   spp;
  logic [prsa_pkg::SPP_W-1:0]   spp_next;

  logic [CW-1:0]                s_rd;
  logic                         s_pend;
  logic [AW-1:0]                s_pidx;
  logic                         found;
  logic [AW-1:0]                f_idx;
  logic [CW-1:0]                sh;
  logic                         sh_pend;
  logic [AW-1:0]                sh_addr;
  logic [AW-1:0]                ni;
  logic                         div_ok;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [prsa_pkg::PAGE_W-1:0]  mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic [prsa_pkg::PAGE_W-1:0]  mem_rdata;

  logic                         div_start;
  logic                         div_done;
  logic [prsa_pkg::TOTAL_W-1:0] div_q;
  logic [prsa_pkg::SPP_W-1:0]   div_r;

  logic [prsa_pkg::PAGE_W-1:0]  key;
  logic                         match;
  logic                         full;
  logic [prsa_pkg::TOTAL_W-1:0] total;
  logic [CMPW-1:0]              prod;
  logic                         range_err;
  logic                         in_page;
  logic [CW-1:0]                tgt;
  logic [CW:0]                  succ_sum;
  logic [CW:0]                  adv_sum;
  logic [AW-1:0]                succ_ni;
  logic [AW-1:0]                adv_ni;

  always_comb begin
    key       = (item.opcode == prsa_pkg::OP_INSERT) ? item.anchor_page : item.page;
    match     = (mem_rdata == key);
    full      = (len == MAX_LEN);
    total     = prsa_pkg::TOTAL_W'(item.slot) + prsa_pkg::TOTAL_W'(item.offset);
    prod      = CMPW'(len) * CMPW'(spp);
    range_err = (CMPW'(item.offset) >= prod) || (prsa_pkg::SPP_W'(item.slot) >= spp);
    in_page   = (total < prsa_pkg::TOTAL_W'(spp));
    tgt       = CW'(f_idx) + CW'(1);
    succ_sum  = (CW+1)'(f_idx) + (CW+1)'(1);
    succ_ni   = (succ_sum == (CW+1)'(len)) ? '0 : AW'(succ_sum);
    // moves never exceeds the ring length once the range check has passed
    adv_sum   = (CW+1)'(f_idx) + (CW+1)'(div_q[CW-1:0]);
    adv_ni    = (adv_sum >= (CW+1)'(len)) ? AW'(adv_sum - (CW+1)'(len)) : AW'(adv_sum);
    div_start = (state == S_ADV_CHK) && !range_err && !in_page;
    out_load  = (state == S_DONE) && (!out_valid || !out_stall);

    res_beat            = res;
    res_beat.page_count = prsa_pkg::COUNT_W'(len);

    if (cfg_data == '0) begin
      spp_next = prsa_pkg::SPP_W'(1);
    end else if (cfg_data > prsa_pkg::MAX_SLOTS) begin
      spp_next = prsa_pkg::MAX_SLOTS;
    end else begin
      spp_next = cfg_data;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = len[AW-1:0];
    mem_wdata = item.page;
    mem_raddr = s_rd[AW-1:0];
    unique case (state)
      S_APPEND: begin
        mem_we = !full;
      end
      S_SHIFT: begin
        mem_we    = sh_pend;
        mem_waddr = sh_addr;
        mem_wdata = mem_rdata;
        mem_raddr = AW'(sh - CW'(1));
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(tgt);
      end
      S_LK_RD: begin
        mem_raddr = ni;
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  prsa_ring_mem #(
    .DEPTH (prsa_pkg::MAX_PAGES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  prsa_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (total),
    .divisor   (spp),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      spp       <= prsa_pkg::SPP_RESET;
      out_valid <= 1'b0;
      s_pend    <= 1'b0;
      sh_pend   <= 1'b0;
      div_ok    <= 1'b0;
    end else begin
      if (cfg_write) begin
        spp <= spp_next;
      end
      // a new division discards any stale completion
      if (div_start) begin
        div_ok <= 1'b0;
      end else if (div_done) begin
        div_ok <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item   <= in_data;
            res    <= '0;
            s_rd   <= '0;
            s_pend <= 1'b0;
            found  <= 1'b0;
            unique case (in_data.opcode)
              prsa_pkg::OP_APPEND:  state <= S_APPEND;
              prsa_pkg::OP_ADVANCE: state <= S_ADV_CHK;
              prsa_pkg::OP_INSERT,
              prsa_pkg::OP_SUCC:    state <= S_SEARCH;
              default:              state <= S_SEARCH;
            endcase
          end
        end

        S_APPEND: begin
          if (full) begin
            res.status <= prsa_pkg::ST_FULL;
          end else begin
            len <= len + CW'(1);
          end
          state <= S_DONE;
        end

        S_ADV_CHK: begin
          if (range_err) begin
            res.status <= prsa_pkg::ST_RANGE;
            state      <= S_DONE;
          end else if (in_page) begin
            res.result_page   <= item.page;
            res.result_slot   <= total[prsa_pkg::SLOT_W-1:0];
            res.result_serial <= item.serial + prsa_pkg::SERIAL_W'(item.offset);
            state             <= S_DONE;
          end else begin
            state <= S_SEARCH;
          end
        end

        // one read issued per cycle, compared the cycle after
        S_SEARCH: begin
          if (s_pend && match) begin
            found  <= 1'b1;
            f_idx  <= s_pidx;
            s_pend <= 1'b0;
            state  <= S_AFTER;
          end else if (s_rd >= len) begin
            s_pend <= 1'b0;
            state  <= S_AFTER;
          end else begin
            s_pend <= 1'b1;
            s_pidx <= s_rd[AW-1:0];
            s_rd   <= s_rd + CW'(1);
          end
        end

        S_AFTER: begin
          if (!found) begin
            res.status <= prsa_pkg::ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            unique case (item.opcode)
              prsa_pkg::OP_INSERT: begin
                if (full) begin
                  res.status <= prsa_pkg::ST_FULL;
                  state      <= S_DONE;
                end else begin
                  sh      <= len;
                  sh_pend <= 1'b0;
                  state   <= S_SHIFT;
                end
              end
              prsa_pkg::OP_SUCC: begin
                ni    <= succ_ni;
                state <= S_LK_RD;
              end
              prsa_pkg::OP_ADVANCE: begin
                if (div_ok) begin
                  ni                <= adv_ni;
                  res.result_slot   <= div_r[prsa_pkg::SLOT_W-1:0];
                  res.result_serial <= item.serial + prsa_pkg::SERIAL_W'(item.offset);
                  state             <= S_LK_RD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // read entry sh-1 now, write it to sh on the next cycle
        S_SHIFT: begin
          if (sh > tgt) begin
            sh_pend <= 1'b1;
            sh_addr <= AW'(sh);
            sh      <= sh - CW'(1);
          end else begin
            sh_pend <= 1'b0;
            if (!sh_pend) begin
              state <= S_INS_WR;
            end
          end
        end

        S_INS_WR: begin
          len   <= len + CW'(1);
          state <= S_DONE;
        end

        S_LK_RD: begin
          state <= S_LK_DATA;
        end

        S_LK_DATA: begin
          res.result_page <= mem_rdata;
          state           <= S_DONE;
        end

        S_DONE: begin
          if (out_load) begin
            out_data <= res_beat;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= MAX_LEN)
    else $error("ring length above capacity");

  a_len_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (((CW+1)'(len) == (CW+1)'($past(len)))
           || ((CW+1)'(len) == (CW+1)'($past(len)) + (CW+1)'(1))))
    else $error("ring length moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.status == prsa_pkg::ST_FULL) |-> full)
    else $error("full status with room in the ring");

  a_moves_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_AFTER && item.opcode == prsa_pkg::OP_ADVANCE && found && div_ok)
      |-> (div_q <= prsa_pkg::TOTAL_W'(len)))
    else $error("page moves exceed ring length");

endmodule

`default_nettype wire

/* rtl/prsa_ring_mem.sv */
`default_nettype none

module prsa_ring_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [prsa_pkg::PAGE_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output      logic [prsa_pkg::PAGE_W-1:0] rdata
);

  logic [prsa_pkg::PAGE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/prsa_divider.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. A start restarts it.
module prsa_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [prsa_pkg::TOTAL_W-1:0] dividend,
  input  wire logic [prsa_pkg::SPP_W-1:0]   divisor,
  output      logic                         done,
  output      logic [prsa_pkg::TOTAL_W-1:0] quotient,
  output      logic [prsa_pkg::SPP_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(prsa_pkg::TOTAL_W + 1);

  logic                         busy;
  logic [CNT_W-1:0]             cnt;
  logic [prsa_pkg::TOTAL_W-1:0] q;
  logic [prsa_pkg::SPP_W-1:0]   r;
  logic [prsa_pkg::SPP_W-1:0]   d;
  logic [prsa_pkg::SPP_W:0]     r_sh;
  logic [prsa_pkg::SPP_W+1:0]   diff;

  always_comb begin
    r_sh = {r, q[prsa_pkg::TOTAL_W-1]};
    diff = {1'b0, r_sh} - {2'b00, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        if (diff[prsa_pkg::SPP_W+1]) begin
          r <= r_sh[prsa_pkg::SPP_W-1:0];
          q <= {q[prsa_pkg::TOTAL_W-2:0], 1'b0};
        end else begin
          r <= diff[prsa_pkg::SPP_W-1:0];
          q <= {q[prsa_pkg::TOTAL_W-2:0], 1'b1};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(prsa_pkg::TOTAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

`default_nettype wire

/* tb/page_ring_slot_address_unit_test.sv */
module page_ring_slot_address_unit_test;

  import prsa_pkg::*;

  localparam int MAX_RING       = MAX_PAGES;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int BEATS_PER_RUN  = 110;

  typedef struct packed {
    logic [MAX_RING-1:0][PAGE_W-1:0] pages;
    logic [COUNT_W-1:0]              len;
  } ring_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [SPP_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;

  in_t  queued_ops[$];
  out_t awaited_results[$];

  // predictor state on the checking side, and a second copy used to shape stimulus
  ring_t            ring_chk = '0;
  ring_t            ring_gen = '0;
  logic [SPP_W-1:0] spp_chk = SPP_RESET;
  logic [SPP_W-1:0] spp_gen = SPP_RESET;

  int   mismatches = 0;
  int   quiet_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  logic beat_in_taken = 1'b0;

  page_ring_slot_address_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [SPP_W-1:0] to_spp(input logic [SPP_W-1:0] v);
    if (v == '0) return SPP_W'(1);
    if (v > MAX_SLOTS) return MAX_SLOTS;
    return v;
  endfunction

  function automatic int find_first(input ring_t r, input logic [PAGE_W-1:0] pg);
    int i;
    int hit;
    hit = -1;
    for (i = 0; i < int'(r.len); i++)
      if (hit < 0 && r.pages[i] == pg) hit = i;
    return hit;
  endfunction

  function automatic out_t apply_ring_op(input ring_t cur, input logic [SPP_W-1:0] spp,
                                         input in_t op, output ring_t nxt);
    out_t               res;
    int                 idx;
    int                 i;
    int                 span;
    logic [TOTAL_W-1:0] total;
    res = '0;
    nxt = cur;
    total = TOTAL_W'(op.slot) + TOTAL_W'(op.offset);
    case (op.opcode)
      OP_APPEND: begin
        if (int'(cur.len) >= MAX_RING) begin
          res.status = ST_FULL;
        end else begin
          nxt.pages[cur.len] = op.page;
          nxt.len = cur.len + COUNT_W'(1);
        end
      end
      OP_INSERT: begin
        // anchor lookup comes before the full test
        idx = find_first(cur, op.anchor_page);
        if (idx < 0) begin
          res.status = ST_NOT_FOUND;
        end else if (int'(cur.len) >= MAX_RING) begin
          res.status = ST_FULL;
        end else begin
          for (i = int'(cur.len); i > idx + 1; i--)
            nxt.pages[i] = cur.pages[i-1];
          nxt.pages[idx+1] = op.page;
          nxt.len = cur.len + COUNT_W'(1);
        end
      end
      OP_ADVANCE: begin
        span = int'(cur.len) * int'(spp);
        if (int'(op.offset) >= span || SPP_W'(op.slot) >= spp) begin
          res.status = ST_RANGE;
        end else if (total < TOTAL_W'(spp)) begin
          // stays in the same page; no search, page need not be in the ring
          res.result_page   = op.page;
          res.result_slot   = total[SLOT_W-1:0];
          res.result_serial = op.serial + SERIAL_W'(op.offset);
        end else begin
          idx = find_first(cur, op.page);
          if (idx < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.result_page   = cur.pages[(idx + int'(total) / int'(spp)) % int'(cur.len)];
            res.result_slot   = SLOT_W'(int'(total) % int'(spp));
            res.result_serial = op.serial + SERIAL_W'(op.offset);
          end
        end
      end
      default: begin
        idx = find_first(cur, op.page);
        if (idx < 0) res.status = ST_NOT_FOUND;
        else res.result_page = cur.pages[(idx + 1) % int'(cur.len)];
      end
    endcase
    res.page_count = nxt.len;
    return res;
  endfunction

  function automatic in_t make_op(input op_t opc, input logic [PAGE_W-1:0] pg,
                                  input logic [PAGE_W-1:0] anc, input logic [SLOT_W-1:0] sl,
                                  input logic [SERIAL_W-1:0] ser,
                                  input logic [OFFSET_W-1:0] off);
    in_t it;
    it.opcode      = opc;
    it.page        = pg;
    it.anchor_page = anc;
    it.slot        = sl;
    it.serial      = ser;
    it.offset      = off;
    return it;
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page();
    if (ring_gen.len != 0 && $urandom_range(99) < 75)
      return ring_gen.pages[$urandom_range(int'(ring_gen.len) - 1)];
    case ($urandom_range(9))
      0: return '0;
      1: return {PAGE_W{1'b1}};
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_beat();
    in_t it;
    int  pick;
    int  span;
    pick = $urandom_range(99);
    if (pick < 14) it.opcode = OP_APPEND;
    else if (pick < 28) it.opcode = OP_INSERT;
    else if (pick < 68) it.opcode = OP_ADVANCE;
    else it.opcode = OP_SUCC;
    if ((it.opcode == OP_APPEND || it.opcode == OP_INSERT) && $urandom_range(99) >= 20)
      it.page = $urandom;
    else
      it.page = pick_page();
    it.anchor_page = pick_page();
    if ($urandom_range(99) < 90) it.slot = SLOT_W'($urandom_range(int'(spp_gen) - 1));
    else it.slot = SLOT_W'($urandom_range(4095));
    // mostly offsets that stay in range, some within the page, some noise
    span = int'(ring_gen.len) * int'(spp_gen);
    pick = $urandom_range(99);
    if (span == 0 || pick < 12)
      it.offset = OFFSET_W'($urandom_range(65535));
    else if (pick < 40 && SPP_W'(it.slot) < spp_gen)
      it.offset = OFFSET_W'($urandom_range(int'(spp_gen) - 1 - int'(it.slot)));
    else
      it.offset = OFFSET_W'($urandom_range(span > 65536 ? 65535 : span - 1));
    if ($urandom_range(99) < 15) it.serial = 32'hFFFF_FFFF - $urandom_range(100);
    else it.serial = $urandom;
    return it;
  endfunction

  task automatic queue_beat(input in_t it);
    ring_t after;
    void'(apply_ring_op(ring_gen, spp_gen, it, after));
    ring_gen = after;
    queued_ops.insert(queued_ops.size(), it);
  endtask

  task automatic write_cfg(input logic [SPP_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= val;
    spp_chk = to_spp(val);
    spp_gen = spp_chk;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (queued_ops.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // sender: holds a beat until taken, idles at random between beats
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_in_taken) begin
      if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= queued_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    out_t  want;
    out_t  got;
    ring_t ring_next;
    logic  took_any;
    beat_in_taken = 1'b0;
    if (!rst) begin
      took_any = 1'b0;
      // check the result side first: a result can never belong to a beat taken this edge
      if (out_valid && !out_stall) begin
        took_any = 1'b1;
        got = out_data;
        if (awaited_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
          if (got.result_page !== want.result_page)
            report_mismatch($sformatf("result_page %h, expected %h",
                                      got.result_page, want.result_page));
          if (got.result_slot !== want.result_slot)
            report_mismatch($sformatf("result_slot %0d, expected %0d",
                                      got.result_slot, want.result_slot));
          if (got.result_serial !== want.result_serial)
            report_mismatch($sformatf("result_serial %h, expected %h",
                                      got.result_serial, want.result_serial));
          if (got.page_count !== want.page_count)
            report_mismatch($sformatf("page_count %0d, expected %0d",
                                      got.page_count, want.page_count));
        end
      end
      if (in_valid && !in_stall) begin
        took_any = 1'b1;
        beat_in_taken = 1'b1;
        want = apply_ring_op(ring_chk, spp_chk, in_data, ring_next);
        ring_chk = ring_next;
        awaited_results.insert(awaited_results.size(), want);
      end
      if (took_any) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int cfg_plan [9];
    int ph;
    int n;
    cfg_plan = '{0, 8191, 4096, 5000, 1, 3, 100, 64, 0};
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct  = 26;
    recv_stall_pct = 56;

    // directed beats at the reset page size
    queue_beat(make_op(OP_ADVANCE, 0, 0, 0, 0, 0));
    queue_beat(make_op(OP_SUCC, 0, 0, 0, 0, 0));
    queue_beat(make_op(OP_INSERT, 1, 0, 0, 0, 0));
    queue_beat(make_op(OP_APPEND, 32'h0, 32'hFFFF_FFFF, 0, 0, 0));
    queue_beat(make_op(OP_APPEND, 32'hFFFF_FFFF, 0, 0, 0, 0));
    queue_beat(make_op(OP_INSERT, 32'h1234_5678, 32'h0, 0, 0, 0));
    queue_beat(make_op(OP_INSERT, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 0, 0, 0));
    queue_beat(make_op(OP_APPEND, 32'h0, 0, 0, 0, 0));
    queue_beat(make_op(OP_APPEND, 32'h5A5A_5A5A, 0, 0, 0, 0));
    queue_beat(make_op(OP_SUCC, 32'h0, 0, 0, 0, 0));
    queue_beat(make_op(OP_SUCC, 32'h5A5A_5A5A, 0, 0, 0, 0));
    queue_beat(make_op(OP_SUCC, 32'h7, 0, 0, 0, 0));
    queue_beat(make_op(OP_ADVANCE, 32'd99, 0, 10, 1, 20));
    queue_beat(make_op(OP_ADVANCE, 32'h0, 0, 64, 5, 0));
    queue_beat(make_op(OP_ADVANCE, 32'h0, 0, 12'hFFF, 5, 0));
    queue_beat(make_op(OP_ADVANCE, 32'h0, 0, 0, 5,
                       OFFSET_W'(int'(ring_gen.len) * int'(spp_gen))));
    queue_beat(make_op(OP_ADVANCE, 32'h0, 0, 63, 32'hFFFF_FFFF,
                       OFFSET_W'(int'(ring_gen.len) * int'(spp_gen) - 1)));
    queue_beat(make_op(OP_ADVANCE, 32'd99, 0, 0, 7, 64));
    queue_beat(make_op(OP_ADVANCE, 32'hFFFF_FFFF, 0, 63, 32'hFFFF_FFFF, 1));
    queue_beat(make_op(OP_INSERT, 32'h3, 32'd77, 0, 0, 0));
    queue_beat(make_op(OP_ADVANCE, 32'h0, 0, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF));
    drain();

    for (ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct  = 56;
        recv_stall_pct = 26;
      end
      if (ph == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (ph == 8) write_cfg(SPP_W'($urandom_range(1, 8191)));
      else write_cfg(SPP_W'(cfg_plan[ph]));
      for (n = 0; n < BEATS_PER_RUN; n++) begin
        // sender goes quiet halfway until the unit has answered everything
        if (ph == 4 && n == BEATS_PER_RUN / 2) drain();
        queue_beat(random_beat());
      end
      if (ph == 1) begin
        // long hold-off while beats keep coming, so the unit backs up
        @(posedge clk);
        hold_toggle = ~hold_toggle;
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/prsa_pkg.sv
rtl/prsa_ring_mem.sv
rtl/prsa_divider.sv
rtl/page_ring_slot_address_unit.sv
tb/page_ring_slot_address_unit_test.sv
